### sv/mlpc_pkg.sv
`timescale 1ns / 1ps

package mlpc_pkg;

	localparam int CNT_W  = 10;
	localparam int MODE_W = 3;
	localparam int LVL_W  = 8;
	localparam int CFG_IW = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF     = 3'd0,
		MODE_ON      = 3'd1,
		MODE_SLOW    = 3'd2,
		MODE_FAST    = 3'd3,
		MODE_FLASH   = 3'd4,
		MODE_BREATHE = 3'd5
	} mode_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_SLOW_PERIOD  = 3'd0,
		REG_SLOW_ON      = 3'd1,
		REG_FAST_PERIOD  = 3'd2,
		REG_FAST_ON      = 3'd3,
		REG_FLASH_PERIOD = 3'd4,
		REG_FLASH_ON     = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SET,
		ST_TICK,
		ST_DIV,
		ST_DIVEND,
		ST_DONE
	} state_t;

	typedef struct packed {
		mode_t            mode;
		logic [CNT_W-1:0] count;
	} entry_t;

	localparam logic [CNT_W-1:0] RST_SLOW_PERIOD  = 10'd1000;
	localparam logic [CNT_W-1:0] RST_SLOW_ON      = 10'd500;
	localparam logic [CNT_W-1:0] RST_FAST_PERIOD  = 10'd100;
	localparam logic [CNT_W-1:0] RST_FAST_ON      = 10'd50;
	localparam logic [CNT_W-1:0] RST_FLASH_PERIOD = 10'd1000;
	localparam logic [CNT_W-1:0] RST_FLASH_ON     = 10'd50;

	localparam logic [CNT_W-1:0] BREATHE_PERIOD = 10'd255;
	localparam logic [LVL_W-1:0] LEVEL_TOP      = 8'd255;

	// remainder unit: one dividend bit per step
	localparam int DIV_STEPS = CNT_W + 1;

endpackage

### sv/mlpc_if.sv
`timescale 1ns / 1ps

interface mlpc_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [1:0] led_index;
	logic [2:0] new_mode;

	modport source (output valid, output opcode, output led_index, output new_mode,
		input ready);
	modport sink (input valid, input opcode, input led_index, input new_mode,
		output ready);
endinterface

interface mlpc_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] led_lit;

	modport source (output valid, output led_lit, input ready);
	modport sink (input valid, input led_lit, output ready);
endinterface

### sv/multi_led_pattern_controller.sv
`timescale 1ns / 1ps

// Six-mode LED pattern generator (off, on, three blink rates, breathe) for up to
// NUM_LEDS pins; led_lit shows pins 0 to 3. Each LED's mode and phase count sit in
// one synchronous memory that is read, updated and written back one LED per cycle
// while no LED is in the remainder unit. A set-mode word reads its entry, then gives
// its result (skipping the read for an index of NUM_LEDS or more); a tick walks all
// LEDs, sending a blinking LED whose count overran a period cut by a register write
// through a bit-serial remainder unit. The next word is taken while a result still
// waits. Registers must be written only while idle; the block does not enforce it.
module multi_led_pattern_controller
	import mlpc_pkg::*;
#(
	parameter int NUM_LEDS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	mlpc_in_if.sink             in_ch,
	mlpc_out_if.source          out_ch,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CNT_W-1:0]    cfg_wdata
);

	localparam int IW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam logic [IW-1:0] LAST = IW'(NUM_LEDS - 1);
	localparam logic [4:0] COUNT5 = 5'(NUM_LEDS);

	state_t state_q, state_d;

	logic [CNT_W-1:0] slow_per_q, slow_on_q, fast_per_q, fast_on_q, flash_per_q, flash_on_q;
	logic [LVL_W-1:0] level_q;
	logic             rising_q;
	logic [NUM_LEDS-1:0] pin_q;
	logic [NUM_LEDS-1:0] vld_q;
	logic [IW-1:0]    led_q, led_d;
	mode_t            mode_q, mode_d;
	logic             out_valid_q;
	logic [3:0]       out_lit_q;
	logic [3:0]       lit_w;

	entry_t           mem [NUM_LEDS];
	entry_t           rd_data_s1;
	logic             rd_vld_s1;
	logic             rd_en, wr_en;
	logic [IW-1:0]    rd_addr, wr_addr;
	entry_t           wr_data, ent;

	logic [CNT_W:0]   rem_q, dvd_q, div_try;
	logic [CNT_W-1:0] dper_q;
	logic [3:0]       dcnt_q;
	logic             div_ld;
	logic [CNT_W:0]   c1;
	logic [CNT_W-1:0] per, pe;
	logic             adv_mode;

	mode_t            f_mode;
	logic [CNT_W-1:0] f_nc, f_thr;
	logic             f_pin;
	logic [LVL_W-1:0] f_level;
	logic             f_rising;
	logic             fin;
	logic             pin_we, pin_val;
	logic             out_ld;
	logic [4:0]       idx5;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.led_lit = out_lit_q;

	assign idx5 = {3'b000, in_ch.led_index};
	assign ent  = rd_vld_s1 ? rd_data_s1 : '0;

	// advance of the entry just read
	always_comb begin
		adv_mode = 1'b1;
		case (ent.mode)
			MODE_SLOW:    per = slow_per_q;
			MODE_FAST:    per = fast_per_q;
			MODE_FLASH:   per = flash_per_q;
			MODE_BREATHE: per = BREATHE_PERIOD;
			default: begin
				per      = BREATHE_PERIOD;
				adv_mode = 1'b0;
			end
		endcase
		pe = (per == '0) ? CNT_W'(1) : per;
		c1 = {1'b0, ent.count} + (CNT_W+1)'(1);
	end

	assign div_try = {rem_q[CNT_W-1:0], dvd_q[CNT_W]};

	// pin and breathe level after a count update
	always_comb begin
		case (f_mode)
			MODE_SLOW:  f_thr = slow_on_q;
			MODE_FAST:  f_thr = fast_on_q;
			MODE_FLASH: f_thr = flash_on_q;
			default:    f_thr = {2'b00, level_q};
		endcase
		f_pin    = (f_nc < f_thr);
		f_level  = level_q;
		f_rising = rising_q;
		if (rising_q) begin
			if (level_q != LEVEL_TOP) f_level = level_q + LVL_W'(1);
			f_rising = (f_level != LEVEL_TOP);
		end else begin
			if (level_q != '0) f_level = level_q - LVL_W'(1);
			f_rising = (f_level == '0);
		end
	end

	always_comb begin
		state_d = state_q;
		led_d   = led_q;
		mode_d  = mode_q;
		rd_en   = 1'b0;
		rd_addr = led_q;
		wr_en   = 1'b0;
		wr_addr = led_q;
		wr_data = '0;
		div_ld  = 1'b0;
		fin     = 1'b0;
		f_mode  = ent.mode;
		f_nc    = c1[CNT_W-1:0];
		pin_we  = 1'b0;
		pin_val = 1'b0;
		out_ld  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.opcode == OP_SET) begin
						mode_d = mode_t'(in_ch.new_mode);
						led_d  = IW'(idx5);
						if (idx5 < COUNT5) begin
							rd_en   = 1'b1;
							rd_addr = IW'(idx5);
							state_d = ST_SET;
						end else begin
							state_d = ST_DONE;
						end
					end else begin
						led_d   = '0;
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = ST_TICK;
					end
				end
			end
			ST_SET: begin
				if (ent.mode != mode_q) begin
					wr_en   = 1'b1;
					wr_data = '{mode: mode_q, count: '0};
				end
				state_d = ST_DONE;
			end
			ST_TICK: begin
				fin = 1'b1;
				case (ent.mode)
					MODE_OFF: begin
						pin_we  = 1'b1;
						pin_val = 1'b0;
					end
					MODE_ON: begin
						pin_we  = 1'b1;
						pin_val = 1'b1;
					end
					default: begin
						if (adv_mode) begin
							if (c1 <= {1'b0, pe}) begin
								if (c1 == {1'b0, pe}) f_nc = '0;
								wr_en   = 1'b1;
								wr_data = '{mode: ent.mode, count: f_nc};
								pin_we  = 1'b1;
								pin_val = f_pin;
							end else begin
								fin     = 1'b0;
								div_ld  = 1'b1;
								mode_d  = ent.mode;
								state_d = ST_DIV;
							end
						end
					end
				endcase
			end
			ST_DIV: begin
				if (dcnt_q == 4'(DIV_STEPS - 1)) state_d = ST_DIVEND;
			end
			ST_DIVEND: begin
				fin     = 1'b1;
				f_mode  = mode_q;
				f_nc    = rem_q[CNT_W-1:0];
				wr_en   = 1'b1;
				wr_data = '{mode: mode_q, count: f_nc};
				pin_we  = 1'b1;
				pin_val = f_pin;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (fin) begin
			if (led_q == LAST) begin
				state_d = ST_DONE;
			end else begin
				led_d   = led_q + IW'(1);
				rd_en   = 1'b1;
				rd_addr = led_q + IW'(1);
				state_d = ST_TICK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (div_ld) begin
			rem_q  <= '0;
			dvd_q  <= c1;
			dper_q <= pe;
			dcnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q  <= (div_try >= {1'b0, dper_q}) ? div_try - {1'b0, dper_q} : div_try;
			dvd_q  <= {dvd_q[CNT_W-1:0], 1'b0};
			dcnt_q <= dcnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			led_q       <= '0;
			mode_q      <= MODE_OFF;
			rd_vld_s1   <= 1'b0;
			vld_q       <= '0;
			pin_q       <= '0;
			level_q     <= '0;
			rising_q    <= 1'b1;
			out_valid_q <= 1'b0;
			out_lit_q   <= '0;
			slow_per_q  <= RST_SLOW_PERIOD;
			slow_on_q   <= RST_SLOW_ON;
			fast_per_q  <= RST_FAST_PERIOD;
			fast_on_q   <= RST_FAST_ON;
			flash_per_q <= RST_FLASH_PERIOD;
			flash_on_q  <= RST_FLASH_ON;
		end else begin
			state_q <= state_d;
			led_q   <= led_d;
			mode_q  <= mode_d;
			if (rd_en) rd_vld_s1 <= vld_q[rd_addr];
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			if (pin_we) pin_q[led_q] <= pin_val;
			if (fin && pin_we && f_mode == MODE_BREATHE) begin
				level_q  <= f_level;
				rising_q <= f_rising;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
				out_lit_q   <= lit_w;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SLOW_PERIOD:  slow_per_q  <= cfg_wdata;
					REG_SLOW_ON:      slow_on_q   <= cfg_wdata;
					REG_FAST_PERIOD:  fast_per_q  <= cfg_wdata;
					REG_FAST_ON:      fast_on_q   <= cfg_wdata;
					REG_FLASH_PERIOD: flash_per_q <= cfg_wdata;
					REG_FLASH_ON:     flash_on_q  <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_lit
		if (b < NUM_LEDS) begin : g_on
			assign lit_w[b] = pin_q[b];
		end else begin : g_off
			assign lit_w[b] = 1'b0;
		end
	end

endmodule

### sv/mlpc_checker.sv
`timescale 1ns / 1ps

module mlpc_checker #(
	parameter int NUM_LEDS = 4
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] led_lit
);

	localparam int USED = (NUM_LEDS < 4) ? NUM_LEDS : 4;
	localparam logic [3:0] HI_MASK = ~4'((5'd1 << USED) - 5'd1);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(led_lit))
		else $error("output word changed while stalled");

	// one word in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without preceding work");

	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (led_lit & HI_MASK) == 4'h0)
		else $error("absent LED shown lit");

endmodule

bind multi_led_pattern_controller mlpc_checker #(.NUM_LEDS(NUM_LEDS)) u_mlpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.led_lit   (out_ch.led_lit)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top
	import mlpc_pkg::*;
;

	localparam int LED_N       = 4;
	localparam int REG_N       = 6;
	localparam int PHASE_N     = 7;
	localparam int PHASE_WORDS = 140;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 300;
	localparam int DIR_N       = 26;

	localparam logic [MODE_W-1:0] HOLD_MODE_LO = 3'd6;
	localparam logic [MODE_W-1:0] HOLD_MODE_HI = 3'd7;

	typedef struct packed {
		opcode_t           op;
		logic [1:0]        idx;
		logic [MODE_W-1:0] mode;
		logic              typed;
		logic [3:0]        lit;
	} dir_row_t;

	dir_row_t dir_rows [DIR_N] = '{
		'{OP_TICK, 2'd0, MODE_OFF,     1'b1, 4'h0},
		'{OP_SET,  2'd0, MODE_ON,      1'b1, 4'h0},
		'{OP_TICK, 2'd3, HOLD_MODE_HI, 1'b1, 4'h1},
		'{OP_SET,  2'd1, MODE_ON,      1'b1, 4'h1},
		'{OP_SET,  2'd0, MODE_ON,      1'b1, 4'h1},
		'{OP_TICK, 2'd0, MODE_OFF,     1'b1, 4'h3},
		'{OP_SET,  2'd2, MODE_BREATHE, 1'b1, 4'h3},
		'{OP_TICK, 2'd0, MODE_OFF,     1'b0, 4'h0},
		'{OP_SET,  2'd3, HOLD_MODE_HI, 1'b0, 4'h0},
		'{OP_TICK, 2'd0, MODE_OFF,     1'b0, 4'h0},
		'{OP_SET,  2'd3, HOLD_MODE_LO, 1'b0, 4'h0},
		'{OP_SET,  2'd1, MODE_SLOW,    1'b0, 4'h0},
		'{OP_TICK, 2'd0, MODE_OFF,     1'b0, 4'h0},
		'{OP_SET,  2'd0, MODE_FAST,    1'b0, 4'h0},
		'{OP_TICK, 2'd0, MODE_OFF,     1'b0, 4'h0},
		'{OP_SET,  2'd3, MODE_FLASH,   1'b0, 4'h0},
		'{OP_TICK, 2'd0, MODE_OFF,     1'b0, 4'h0},
		'{OP_TICK, 2'd1, MODE_ON,      1'b0, 4'h0},
		'{OP_SET,  2'd2, MODE_OFF,     1'b0, 4'h0},
		'{OP_TICK, 2'd0, MODE_OFF,     1'b0, 4'h0},
		'{OP_SET,  2'd0, MODE_BREATHE, 1'b0, 4'h0},
		'{OP_SET,  2'd1, MODE_BREATHE, 1'b0, 4'h0},
		'{OP_SET,  2'd2, MODE_BREATHE, 1'b0, 4'h0},
		'{OP_SET,  2'd3, MODE_BREATHE, 1'b0, 4'h0},
		'{OP_TICK, 2'd2, MODE_FLASH,   1'b0, 4'h0},
		'{OP_TICK, 2'd1, HOLD_MODE_LO, 1'b0, 4'h0}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CNT_W-1:0]  cfg_wdata;

	mlpc_in_if  in_ch ();
	mlpc_out_if out_ch ();

	multi_led_pattern_controller #(.NUM_LEDS(LED_N)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// pattern state mirror
	logic [MODE_W-1:0] mode_mirror [LED_N];
	logic [CNT_W-1:0]  led_phase [LED_N];
	logic              led_pin   [LED_N];
	logic [LVL_W-1:0]  level;
	logic              rising;
	logic [CNT_W-1:0]  regs      [REG_N];

	logic [3:0] lit_q [$];
	int         errors;
	int         words_sent;
	int         cycles;
	bit         no_idle;
	logic       hold_off;

	function automatic logic [CNT_W-1:0] next_phase(logic [CNT_W-1:0] c, logic [CNT_W-1:0] p);
		int unsigned per;
		per = (p == 0) ? 1 : 32'(p);
		return CNT_W'((32'(c) + 1) % per);
	endfunction

	function automatic void blink_led(int i, logic [CNT_W-1:0] per, logic [CNT_W-1:0] on_t);
		led_phase[i] = next_phase(led_phase[i], per);
		led_pin[i]   = (led_phase[i] < on_t);
	endfunction

	function automatic void breathe_led(int i);
		led_phase[i] = next_phase(led_phase[i], BREATHE_PERIOD);
		led_pin[i]   = (led_phase[i] < CNT_W'(level));
		if (rising) begin
			if (level < LEVEL_TOP)
				level++;
			if (level == LEVEL_TOP)
				rising = 1'b0;
		end else begin
			if (level > 0)
				level--;
			if (level == 0)
				rising = 1'b1;
		end
	endfunction

	function automatic logic [3:0] predict_lit(opcode_t op, logic [1:0] idx, logic [MODE_W-1:0] m);
		logic [3:0] lit;
		if (op == OP_SET) begin
			if (idx < LED_N && mode_mirror[idx] != m) begin
				mode_mirror[idx] = m;
				led_phase[idx]   = '0;
			end
		end else begin
			for (int i = 0; i < LED_N; i++) begin
				case (mode_mirror[i])
					MODE_OFF:     led_pin[i] = 1'b0;
					MODE_ON:      led_pin[i] = 1'b1;
					MODE_SLOW:    blink_led(i, regs[REG_SLOW_PERIOD], regs[REG_SLOW_ON]);
					MODE_FAST:    blink_led(i, regs[REG_FAST_PERIOD], regs[REG_FAST_ON]);
					MODE_FLASH:   blink_led(i, regs[REG_FLASH_PERIOD], regs[REG_FLASH_ON]);
					MODE_BREATHE: breathe_led(i);
					default: ;
				endcase
			end
		end
		lit = '0;
		for (int i = 0; i < LED_N && i < 4; i++)
			lit[i] = led_pin[i];
		return lit;
	endfunction

	function automatic int idle_draw();
		return no_idle ? 0 : $urandom_range(0, 4);
	endfunction

	task automatic send_word(opcode_t op, logic [1:0] idx, logic [MODE_W-1:0] m,
		logic typed, logic [3:0] typed_lit);
		int         gap;
		logic [3:0] pred;
		gap = idle_draw();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.opcode    <= op;
		in_ch.led_index <= idx;
		in_ch.new_mode  <= m;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pred = predict_lit(op, idx, m);
		lit_q.push_back(typed ? typed_lit : pred);
		words_sent++;
	endtask

	task automatic drain_results(int extra);
		in_ch.valid <= 1'b0;
		while (lit_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_regs(logic [CNT_W-1:0] vals [REG_N]);
		for (int r = 0; r < REG_N; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_idx_t'(r);
			cfg_wdata <= vals[r];
			regs[r]   = vals[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// long receiver hold-off while the sender keeps offering words
	initial begin
		hold_off = 1'b0;
		while (words_sent < HOLD_AT)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		int         rx_gap;
		logic [3:0] want;
		out_ch.ready = 1'b0;
		rx_gap = 0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (lit_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual led_lit %h",
						$time, out_ch.led_lit);
					errors++;
				end else begin
					want = lit_q.pop_front();
					if (out_ch.led_lit !== want) begin
						$display("%0t: led_lit mismatch, expected %h, actual %h",
							$time, want, out_ch.led_lit);
						errors++;
					end
				end
				rx_gap = idle_draw();
			end
			if (rx_gap > 0) begin
				rx_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= arst_n && !hold_off;
			end
		end
	end

	initial begin
		logic [CNT_W-1:0] cfg_vals [REG_N];
		logic [CNT_W-1:0] per;
		logic [CNT_W-1:0] on_t;
		errors     = 0;
		words_sent = 0;
		cycles     = 0;
		no_idle    = 1'b0;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.opcode    = OP_TICK;
		in_ch.led_index = '0;
		in_ch.new_mode  = '0;

		for (int i = 0; i < LED_N; i++) begin
			mode_mirror[i] = MODE_OFF;
			led_phase[i]   = '0;
			led_pin[i]     = 1'b0;
		end
		level  = '0;
		rising = 1'b1;
		regs[REG_SLOW_PERIOD]  = RST_SLOW_PERIOD;
		regs[REG_SLOW_ON]      = RST_SLOW_ON;
		regs[REG_FAST_PERIOD]  = RST_FAST_PERIOD;
		regs[REG_FAST_ON]      = RST_FAST_ON;
		regs[REG_FLASH_PERIOD] = RST_FLASH_PERIOD;
		regs[REG_FLASH_ON]     = RST_FLASH_ON;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int k = 0; k < DIR_N; k++)
			send_word(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].mode,
				dir_rows[k].typed, dir_rows[k].lit);
		drain_results(8);

		for (int ph = 0; ph < PHASE_N; ph++) begin
			for (int r = 0; r < REG_N; r += 2) begin
				case (ph)
					0, 4: begin
						per  = CNT_W'($urandom_range(500, 1023));
						on_t = CNT_W'($urandom_range(0, 1023));
					end
					2, 5: begin
						// short periods catch counters left above the new period
						per  = CNT_W'($urandom_range(0, 16));
						on_t = CNT_W'($urandom_range(0, 18));
					end
					3: begin
						per  = '1;
						on_t = '1;
					end
					default: begin
						per  = 10'd1;
						on_t = '0;
					end
				endcase
				cfg_vals[r]     = per;
				cfg_vals[r + 1] = on_t;
			end
			if (ph == 1) begin
				cfg_vals[REG_FAST_ON]      = '1;
				cfg_vals[REG_FLASH_PERIOD] = '0;
				cfg_vals[REG_FLASH_ON]     = 10'd1;
			end
			if (ph == PHASE_N - 1) begin
				cfg_vals[REG_SLOW_PERIOD]  = RST_SLOW_PERIOD;
				cfg_vals[REG_SLOW_ON]      = RST_SLOW_ON;
				cfg_vals[REG_FAST_PERIOD]  = RST_FAST_PERIOD;
				cfg_vals[REG_FAST_ON]      = RST_FAST_ON;
				cfg_vals[REG_FLASH_PERIOD] = RST_FLASH_PERIOD;
				cfg_vals[REG_FLASH_ON]     = RST_FLASH_ON;
			end
			write_regs(cfg_vals);
			no_idle = (ph == 3);

			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n == PHASE_WORDS / 2)
					drain_results(1);
				if ($urandom_range(0, 9) < 7)
					send_word(OP_TICK, 2'($urandom), 3'($urandom), 1'b0, 4'h0);
				else
					send_word(OP_SET, 2'($urandom), 3'($urandom), 1'b0, 4'h0);
			end
			drain_results(8);
		end

		drain_results(20);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
